// ----- design/rsi_pkg.sv -----
// rsi_pkg: shared defaults for the ray / sphere intersection pipeline
`default_nettype none
package rsi_pkg;
    localparam int unsigned CoordWidthDef = 32;
    localparam int unsigned FracBitsDef   = 16;
endpackage
`default_nettype wire

// ----- design/rsi_sqrt.sv -----
// rsi_sqrt: pipelined integer square root, one result bit per stage
`default_nettype none
module rsi_sqrt #(
    parameter int unsigned IN_W   = 64,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [IN_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_vld,
    output logic [IN_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]        o_side
);
    import rsi_pkg::*;

    localparam int unsigned R  = IN_W / 2;
    localparam int unsigned RW = R + 3;

    logic              s_vld  [R+1];
    logic [RW-1:0]     s_rem  [R+1];
    logic [R-1:0]      s_root [R+1];
    logic [IN_W-1:0]   s_rad  [R+1];
    logic [SIDE_W-1:0] s_side [R+1];

    logic              r_vld  [R];
    logic [RW-1:0]     r_rem  [R];
    logic [R-1:0]      r_root [R];
    logic [IN_W-1:0]   r_rad  [R];
    logic [SIDE_W-1:0] r_side [R];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = i_rad;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < R; k++) begin : g_step
        logic [RW-1:0] n_acc;
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_rem;
        logic [R-1:0]  n_root;

        always_comb begin
            n_acc   = {s_rem[k][RW-3:0], s_rad[k][IN_W-1 -: 2]};
            n_trial = {1'b0, s_root[k], 2'b01};
            if (n_acc >= n_trial) begin
                n_rem  = n_acc - n_trial;
                n_root = {s_root[k][R-2:0], 1'b1};
            end else begin
                n_rem  = n_acc;
                n_root = {s_root[k][R-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_rad[k]  <= s_rad[k] << 2;
            r_side[k] <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld[k];
        assign s_rem[k+1]  = r_rem[k];
        assign s_root[k+1] = r_root[k];
        assign s_rad[k+1]  = r_rad[k];
        assign s_side[k+1] = r_side[k];
    end

    assign o_vld  = s_vld[R];
    assign o_root = s_root[R];
    assign o_side = s_side[R];

    logic [IN_W:0] sq_lo;
    logic [IN_W:0] sq_hi;
    assign sq_lo = (IN_W+1)'(o_root) * (IN_W+1)'(o_root);
    assign sq_hi = ((IN_W+1)'(o_root) + 1'b1) * ((IN_W+1)'(o_root) + 1'b1);

    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> sq_lo <= (IN_W+1)'($past(i_rad, R)))
        else $error("square root too large");
    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> sq_hi > (IN_W+1)'($past(i_rad, R)))
        else $error("square root too small");
endmodule
`default_nettype wire

// ----- design/rsi_div.sv -----
// rsi_div: pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rsi_div #(
    parameter int unsigned N_W    = 66,
    parameter int unsigned D_W    = 32,
    parameter int unsigned Q_W    = 35,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [N_W-1:0]      i_num,
    input  wire logic [D_W-1:0]      i_den,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_vld,
    output logic [Q_W-1:0]           o_quo,
    output logic [SIDE_W-1:0]        o_side
);
    import rsi_pkg::*;

    logic              s_vld  [Q_W+1];
    logic [D_W-1:0]    s_rem  [Q_W+1];
    logic [Q_W-1:0]    s_low  [Q_W+1];
    logic [Q_W-1:0]    s_quo  [Q_W+1];
    logic [D_W-1:0]    s_den  [Q_W+1];
    logic [SIDE_W-1:0] s_side [Q_W+1];

    logic              r_vld  [Q_W];
    logic [D_W-1:0]    r_rem  [Q_W];
    logic [Q_W-1:0]    r_low  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [D_W-1:0]    r_den  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    // quotient fits in Q_W bits, so the top of the dividend is below the divisor
    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = D_W'(i_num[N_W-1:Q_W]);
    assign s_low[0]  = i_num[Q_W-1:0];
    assign s_quo[0]  = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [D_W:0]   n_acc;
        logic [D_W-1:0] n_rem;
        logic [Q_W-1:0] n_quo;

        always_comb begin
            n_acc = {s_rem[k], s_low[k][Q_W-1]};
            if (n_acc >= {1'b0, s_den[k]}) begin
                n_rem = D_W'(n_acc - {1'b0, s_den[k]});
                n_quo = {s_quo[k][Q_W-2:0], 1'b1};
            end else begin
                n_rem = D_W'(n_acc);
                n_quo = {s_quo[k][Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_low[k]  <= s_low[k] << 1;
            r_quo[k]  <= n_quo;
            r_den[k]  <= s_den[k];
            r_side[k] <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld[k];
        assign s_rem[k+1]  = r_rem[k];
        assign s_low[k+1]  = r_low[k];
        assign s_quo[k+1]  = r_quo[k];
        assign s_den[k+1]  = r_den[k];
        assign s_side[k+1] = r_side[k];
    end

    assign o_vld  = s_vld[Q_W];
    assign o_quo  = s_quo[Q_W];
    assign o_side = s_side[Q_W];

    logic [Q_W+D_W-1:0] prod;
    assign prod = (Q_W+D_W)'(o_quo) * (Q_W+D_W)'(s_den[Q_W]);

    a_quo_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && s_den[Q_W] != '0 |-> prod <= (Q_W+D_W)'($past(i_num, Q_W)))
        else $error("quotient too large");
endmodule
`default_nettype wire

// ----- design/ray_sphere_intersect_unit.sv -----
// ray_sphere_intersect_unit: top level of the ray / sphere intersection pipeline
// One ray and one sphere enter per clock whenever start is high; busy never rises.
// Each item leaves through the output register at the end of the pipeline as a
// one-cycle o_valid strobe with o_hit_distance and o_hit_flag. The receiver cannot
// stall the block, so every result must be taken in the cycle it is shown. The
// latency is set by the bit-per-stage square root of |d|^2, the bit-per-stage divider
// for the projection and the bit-per-stage square root of the discriminant. A miss,
// a zero direction included, returns -1.0 with the flag clear; a hit distance is
// saturated.
`default_nettype none
module ray_sphere_intersect_unit #(
    parameter int unsigned COORD_WIDTH = rsi_pkg::CoordWidthDef,
    parameter int unsigned FRAC_BITS   = rsi_pkg::FracBitsDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_z,
    input  wire logic        [COORD_WIDTH-2:0] i_sphere_radius,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_hit_distance,
    output logic                               o_hit_flag
);
    import rsi_pkg::*;

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned XW    = W + 3;
    localparam int unsigned H     = (XW + 1) / 2;
    localparam int unsigned XH    = XW - H;
    localparam int unsigned SUM_W = 2 * XW + 1;
    localparam int unsigned SR_W  = SUM_W + 1;
    localparam int unsigned SQ_W  = SR_W / 2;
    localparam int unsigned DW    = W + 6;
    localparam longint SatHiL = (longint'(1) <<< (W - 1)) - 1;
    localparam longint SatLoL = -(longint'(1) <<< (W - 1));
    localparam longint MissL  = -(longint'(1) <<< FRAC_BITS);
    localparam logic signed [W-1:0] MissDist =
        (MissL < SatLoL) ? W'(SatLoL) : W'(MissL);
    localparam logic signed [DW-1:0] SatHi = DW'(SatHiL);
    localparam logic signed [DW-1:0] SatLo = DW'(SatLoL);
    localparam int unsigned S1_W  = 1 + (2*W+2) + (2*W+2) + (2*W-2) + 1;
    localparam int unsigned DV_W  = 1 + (2*W+2) + (2*W-2) + 1;
    localparam int unsigned S2_W  = 1 + XW + 1;

    assign busy = 1'b0;

    // stage 1: input capture, oc = origin - center
    logic                  r1_vld;
    logic signed [W-1:0]   r1_d  [3];
    logic signed [W:0]     r1_oc [3];
    logic        [W-2:0]   r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d[0]  <= i_dir_x;
        r1_d[1]  <= i_dir_y;
        r1_d[2]  <= i_dir_z;
        r1_oc[0] <= (W+1)'(i_origin_x) - (W+1)'(i_center_x);
        r1_oc[1] <= (W+1)'(i_origin_y) - (W+1)'(i_center_y);
        r1_oc[2] <= (W+1)'(i_origin_z) - (W+1)'(i_center_z);
        r1_rad   <= i_sphere_radius;
    end

    // stage 2: products
    logic                    r2_vld;
    logic signed [2*W-1:0]   r2_dd  [3];
    logic signed [2*W:0]     r2_doc [3];
    logic signed [2*W+1:0]   r2_oo  [3];
    logic        [2*W-3:0]   r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_dd[i]  <= (2*W)'(r1_d[i]) * (2*W)'(r1_d[i]);
            r2_doc[i] <= (2*W+1)'(r1_d[i]) * (2*W+1)'(r1_oc[i]);
            r2_oo[i]  <= (2*W+2)'(r1_oc[i]) * (2*W+2)'(r1_oc[i]);
        end
        r2_rr <= (2*W-2)'(r1_rad) * (2*W-2)'(r1_rad);
    end

    // stage 3: sums
    logic                  r3_vld;
    logic [2*W-1:0]        r3_len2;
    logic signed [2*W+2:0] r3_dot;
    logic [2*W+1:0]        r3_oc2;
    logic [2*W-3:0]        r3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_len2 <= $unsigned(r2_dd[0]) + $unsigned(r2_dd[1]) + $unsigned(r2_dd[2]);
        r3_dot  <= (2*W+3)'(r2_doc[0]) + (2*W+3)'(r2_doc[1]) + (2*W+3)'(r2_doc[2]);
        r3_oc2  <= $unsigned(r2_oo[0]) + $unsigned(r2_oo[1]) + $unsigned(r2_oo[2]);
        r3_rr   <= r2_rr;
    end

    // stage 4: sign and magnitude of the dot product
    logic              r4_vld;
    logic              r4_dneg;
    logic [2*W+1:0]    r4_dmag;
    logic [2*W-1:0]    r4_len2;
    logic [2*W+1:0]    r4_oc2;
    logic [2*W-3:0]    r4_rr;
    logic              r4_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_dneg <= r3_dot[2*W+2];
        r4_dmag <= r3_dot[2*W+2] ? (2*W+2)'(-r3_dot) : (2*W+2)'(r3_dot);
        r4_len2 <= r3_len2;
        r4_oc2  <= r3_oc2;
        r4_rr   <= r3_rr;
        r4_zero <= (r3_len2 == '0);
    end

    // direction length
    logic              s1_vld;
    logic [W-1:0]      s1_dl;
    logic [S1_W-1:0]   s1_side;
    logic              s1_dneg;
    logic [2*W+1:0]    s1_dmag;
    logic [2*W+1:0]    s1_oc2;
    logic [2*W-3:0]    s1_rr;
    logic              s1_zero;

    rsi_sqrt #(.IN_W(2*W), .SIDE_W(S1_W)) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .i_rad   (r4_len2),
        .i_side  ({r4_dneg, r4_dmag, r4_oc2, r4_rr, r4_zero}),
        .o_vld   (s1_vld),
        .o_root  (s1_dl),
        .o_side  (s1_side)
    );
    assign {s1_dneg, s1_dmag, s1_oc2, s1_rr, s1_zero} = s1_side;

    // projection of oc on the unit direction
    logic              dv_vld;
    logic [XW-1:0]     dv_xmag;
    logic [DV_W-1:0]   dv_side;
    logic              dv_dneg;
    logic [2*W+1:0]    dv_oc2;
    logic [2*W-3:0]    dv_rr;
    logic              dv_zero;

    rsi_div #(.N_W(2*W+2), .D_W(W), .Q_W(XW), .SIDE_W(DV_W)) u_proj_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .i_num   (s1_dmag),
        .i_den   (s1_dl),
        .i_side  ({s1_dneg, s1_oc2, s1_rr, s1_zero}),
        .o_vld   (dv_vld),
        .o_quo   (dv_xmag),
        .o_side  (dv_side)
    );
    assign {dv_dneg, dv_oc2, dv_rr, dv_zero} = dv_side;

    // stage 5: x squared as three half-width products
    logic              r5_vld;
    logic [2*XH-1:0]   r5_hh;
    logic [XH+H-1:0]   r5_hl;
    logic [2*H-1:0]    r5_ll;
    logic              r5_dneg;
    logic [XW-1:0]     r5_xmag;
    logic [2*W+1:0]    r5_oc2;
    logic [2*W-3:0]    r5_rr;
    logic              r5_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_hh   <= (2*XH)'(dv_xmag[XW-1:H]) * (2*XH)'(dv_xmag[XW-1:H]);
        r5_hl   <= (XH+H)'(dv_xmag[XW-1:H]) * (XH+H)'(dv_xmag[H-1:0]);
        r5_ll   <= (2*H)'(dv_xmag[H-1:0]) * (2*H)'(dv_xmag[H-1:0]);
        r5_dneg <= dv_dneg;
        r5_xmag <= dv_xmag;
        r5_oc2  <= dv_oc2;
        r5_rr   <= dv_rr;
        r5_zero <= dv_zero;
    end

    // stage 6: x*x + r*r
    logic              r6_vld;
    logic [SUM_W-1:0]  r6_sum;
    logic              r6_dneg;
    logic [XW-1:0]     r6_xmag;
    logic [2*W+1:0]    r6_oc2;
    logic              r6_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sum  <= (SUM_W'(r5_hh) << (2*H)) + (SUM_W'(r5_hl) << (H+1))
                 + SUM_W'(r5_ll) + SUM_W'(r5_rr);
        r6_dneg <= r5_dneg;
        r6_xmag <= r5_xmag;
        r6_oc2  <= r5_oc2;
        r6_zero <= r5_zero;
    end

    // stage 7: discriminant and hit decision
    logic              r7_vld;
    logic [SUM_W-1:0]  r7_disc;
    logic              r7_hit;
    logic              r7_dneg;
    logic [XW-1:0]     r7_xmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_disc <= r6_sum - SUM_W'(r6_oc2);
        r7_hit  <= !r6_zero && (r6_sum > SUM_W'(r6_oc2));
        r7_dneg <= r6_dneg;
        r7_xmag <= r6_xmag;
    end

    // square root of the discriminant
    logic              s2_vld;
    logic [SQ_W-1:0]   s2_root;
    logic [S2_W-1:0]   s2_side;
    logic              s2_dneg;
    logic [XW-1:0]     s2_xmag;
    logic              s2_hit;

    rsi_sqrt #(.IN_W(SR_W), .SIDE_W(S2_W)) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_vld),
        .i_rad   ({1'b0, r7_disc}),
        .i_side  ({r7_dneg, r7_xmag, r7_hit}),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_side  (s2_side)
    );
    assign {s2_dneg, s2_xmag, s2_hit} = s2_side;

    // output stage: distance = -x - sqrt(disc), saturated; -1.0 on a miss
    logic signed [DW-1:0] xm_s;
    logic signed [DW-1:0] rt_s;
    logic signed [DW-1:0] raw_dist;
    logic signed [W-1:0]  n_dist;

    always_comb begin
        xm_s     = $signed(DW'(s2_xmag));
        rt_s     = $signed(DW'(s2_root));
        raw_dist = s2_dneg ? (xm_s - rt_s) : (-xm_s - rt_s);
        if (!s2_hit) begin
            n_dist = MissDist;
        end else if (raw_dist > SatHi) begin
            n_dist = W'(SatHi);
        end else if (raw_dist < SatLo) begin
            n_dist = W'(SatLo);
        end else begin
            n_dist = W'(raw_dist);
        end
    end

    logic                r_out_vld;
    logic                r_out_flag;
    logic signed [W-1:0] r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_flag <= 1'b0;
        end else begin
            r_out_vld  <= s2_vld;
            r_out_flag <= s2_vld && s2_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist <= n_dist;
    end

    assign o_valid        = r_out_vld;
    assign o_hit_flag     = r_out_flag;
    assign o_hit_distance = r_out_dist;

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_flag |-> o_hit_distance == MissDist)
        else $error("miss without -1.0 distance");
    a_flag_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_flag |-> o_valid)
        else $error("hit flag outside a result");
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_vld |-> ((s1_dl == '0) == s1_zero))
        else $error("zero direction flag disagrees with length");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: directed and randomised ray / sphere stimulus with a scoreboard that predicts each result
`default_nettype none
module testbench;
    import rsi_pkg::*;

    localparam int unsigned CW       = CoordWidthDef;
    localparam int unsigned FB       = FracBitsDef;
    localparam int unsigned LATENCY  = 3 * CW + 15;
    localparam int unsigned MAX_CYC  = 400000;
    localparam int unsigned N_RANDOM = 1100;
    localparam int          ONE      = 1 << FB;

    typedef struct {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
        logic [2:0][CW-1:0] ctr;
        logic [CW-2:0]      rad;
    } t_ray;

    typedef struct {
        logic [CW-1:0] hit_dist;
        logic          hit;
    } t_hit;

    class t_hit_scoreboard;
        t_hit pending_hits[$];
        int   errors = 0;

        function logic [127:0] isqrt128(logic [127:0] n);
            logic [127:0] r;
            logic [127:0] t;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (128'd1 << b);
                if (t * t <= n) r = t;
            end
            return r;
        endfunction

        function logic signed [127:0] sx(logic [CW-1:0] v);
            return {{(128-CW){v[CW-1]}}, v};
        endfunction

        // works out the expected hit for an accepted item
        function void note_ray(t_ray r);
            logic signed [127:0] d[3];
            logic signed [127:0] oc[3];
            logic signed [127:0] len2, dotp, oc2, sum, x, raw_dist, rad;
            logic [127:0]        dl, xm, s;
            logic                neg;
            t_hit                e;
            len2 = 0;
            dotp = 0;
            oc2  = 0;
            for (int i = 0; i < 3; i++) begin
                d[i]  = sx(r.dir[i]);
                oc[i] = sx(r.org[i]) - sx(r.ctr[i]);
                len2 += d[i] * d[i];
                dotp += d[i] * oc[i];
                oc2  += oc[i] * oc[i];
            end
            rad        = {{(129-CW){1'b0}}, r.rad};
            e.hit_dist = -(CW'(ONE));
            e.hit      = 1'b0;
            if (len2 != 0) begin
                dl  = isqrt128(len2);
                neg = dotp < 0;
                xm  = neg ? -dotp : dotp;
                xm  = xm / dl;
                sum = xm * xm + rad * rad;
                if (oc2 < sum) begin
                    s        = isqrt128(sum - oc2);
                    x        = neg ? -xm : xm;
                    raw_dist = -x - s;
                    if (raw_dist > (128'sd1 <<< (CW-1)) - 1)
                        e.hit_dist = {1'b0, {(CW-1){1'b1}}};
                    else if (raw_dist < -(128'sd1 <<< (CW-1)))
                        e.hit_dist = {1'b1, {(CW-1){1'b0}}};
                    else
                        e.hit_dist = raw_dist[CW-1:0];
                    e.hit = 1'b1;
                end
            end
            pending_hits.push_back(e);
        endfunction

        function void check_result(logic [CW-1:0] got_dist, logic hit);
            t_hit e;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: hit_distance %h hit_flag %b", got_dist, hit);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (got_dist !== e.hit_dist) begin
                $error("hit_distance: expected %h, got %h", e.hit_dist, got_dist);
                errors++;
            end
            if (hit !== e.hit) begin
                $error("hit_flag: expected %b, got %b", e.hit, hit);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_ray               ray_in = '{default: '0};
    logic               o_valid;
    logic signed [CW-1:0] o_hit_distance;
    logic               o_hit_flag;
    int unsigned        cycles = 0;
    t_hit_scoreboard    hits = new();

    always #2 i_clk = ~i_clk;

    ray_sphere_intersect_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_origin_x     (ray_in.org[0]),
        .i_origin_y     (ray_in.org[1]),
        .i_origin_z     (ray_in.org[2]),
        .i_dir_x        (ray_in.dir[0]),
        .i_dir_y        (ray_in.dir[1]),
        .i_dir_z        (ray_in.dir[2]),
        .i_center_x     (ray_in.ctr[0]),
        .i_center_y     (ray_in.ctr[1]),
        .i_center_z     (ray_in.ctr[2]),
        .i_sphere_radius(ray_in.rad),
        .o_valid        (o_valid),
        .o_hit_distance (o_hit_distance),
        .o_hit_flag     (o_hit_flag)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n) begin
            if (start && !busy) hits.note_ray(ray_in);
            if (o_valid) hits.check_result(o_hit_distance, o_hit_flag);
        end
    end

    task automatic send_ray(t_ray r);
        @(negedge i_clk);
        start  <= 1'b1;
        ray_in <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        while (hits.pending_hits.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_ray make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                      int cx, int cy, int cz, logic [CW-2:0] rd);
        t_ray r;
        r.org = {CW'(oz), CW'(oy), CW'(ox)};
        r.dir = {CW'(dz), CW'(dy), CW'(dx)};
        r.ctr = {CW'(cz), CW'(cy), CW'(cx)};
        r.rad = rd;
        return r;
    endfunction

    function automatic t_ray random_ray();
        t_ray r;
        int   span;
        if ($urandom_range(0, 9) < 3) begin
            for (int i = 0; i < 3; i++) begin
                r.org[i] = $urandom;
                r.dir[i] = $urandom;
                r.ctr[i] = $urandom;
            end
            r.rad = (CW-1)'($urandom);
            if ($urandom_range(0, 7) == 0) r.dir = '0;
        end else begin
            // a scene: sphere placed roughly along the ray so hits are common
            span = $urandom_range(0, 3) == 0 ? 2000 * ONE : 100 * ONE;
            for (int i = 0; i < 3; i++) begin
                r.org[i] = CW'($signed($urandom_range(0, 2 * span)) - span);
                r.ctr[i] = CW'($signed($urandom_range(0, 2 * span)) - span);
                r.dir[i] = CW'($signed(r.ctr[i] - r.org[i]) >>> $urandom_range(0, 8))
                         + CW'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
            end
            r.rad = (CW-1)'($urandom_range(0, 40 * ONE));
            if ($urandom_range(0, 9) == 0) r.rad = (CW-1)'($urandom);
        end
        return r;
    endfunction

    initial begin
        int sent;
        int burst;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero direction, straight hits, sphere behind, inside, tangent, extremes
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, 3 * ONE, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, -ONE, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0, 2 * ONE));
        send_ray(make_ray(0, ONE, 0, 0, 0, ONE, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 2 * ONE, 0, 0, 0, ONE, 0, 0, 5 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE, ONE));
        send_ray(make_ray(0, 0, 0, 1, 0, 0, 10 * ONE, 0, 0, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0));
        send_ray(make_ray(32'h8000_0000, 0, 0, ONE, 0, 0, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff));
        send_ray(make_ray(32'h7fff_ffff, 0, 0, ONE, 0, 0, 32'h8000_0000, 0, 0, 31'h7fff_ffff));
        send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff));
        send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 31'h7fff_ffff));
        send_ray(make_ray(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, ONE));
        idle_cycles(3);
        drain();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                send_ray(random_ray());
                sent++;
                // pause mid-run until the pipeline has emptied
                if (sent == N_RANDOM / 2) begin
                    idle_cycles(1);
                    drain();
                end
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (hits.errors == 0 && hits.pending_hits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
